// File: rtl/core/checksum_frame_receiver_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the checksum frame receiver
// Shared property wrappers on clock; NOW and NEXT are disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// condition holds in the same cycle
`define CFR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define CFR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checked in and right after reset as well
`define CFR_ASSERT_RST(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cfr_pkg.sv
// ---------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the frame receiver front, queue and back.
// ---------------------------------------------------------------------------
package cfr_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W       = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [7:0] SECOND_SYNC_RESET = 8'hAF;

   // configuration register indexes
   localparam logic CSR_FIRST_SYNC  = 1'b0;
   localparam logic CSR_SECOND_SYNC = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DATA    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_SUM_ERR = 2'd2;
   localparam logic [1:0] ST_LEN_ERR = 2'd3;

   // one finished frame, handed from front to back
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] code;
      logic [7:0] length;
   } frame_desc_type;

   // payload memory write port, front to back
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// File: rtl/core/cfr_front.sv
// ---------------------------------------------------------------------------
// cfr_front
// Byte parser: sync hunt, header capture, checksum, payload store writes.
// ---------------------------------------------------------------------------
module cfr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              rx_byte,
   input  logic                    csr_valid,
   input  logic                    csr_index,
   input  logic [7:0]              csr_data,
   input  cfr_pkg::queue_stat_type q_stat,
   output logic                    q_push,
   output cfr_pkg::frame_desc_type q_desc,
   output cfr_pkg::store_wr_type   st_wr
);
   import cfr_pkg::*;

   typedef enum logic [5:0] {
      PH_SYNC1 = 6'b000001,
      PH_SYNC2 = 6'b000010,
      PH_CODE  = 6'b000100,
      PH_LEN   = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_SUM   = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       code_ff, code_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       first_ff, second_ff;
   logic             accept;
   logic [CNT_W-1:0] count_inc;
   logic [7:0]       sum_add;

   // payload bytes wait while the back still reads the previous frame
   assign full      = q_stat.full || ((phase_ff == PH_DATA) && !q_stat.empty);
   assign accept    = push && !full;
   assign count_inc = count_ff + CNT_W'(1);
   assign sum_add   = sum_ff + rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      code_in     = code_ff;
      sum_in      = sum_ff;
      q_push      = 1'b0;
      q_desc      = '{status: ST_DATA, code: code_ff, length: len_ff};
      st_wr       = '{en: 1'b0, addr: count_ff[ADDR_W-1:0], data: rx_byte};
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == first_ff) begin
                  sum_in   = rx_byte;
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == second_ff) begin
                  sum_in   = sum_add;
                  phase_in = PH_CODE;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_CODE: begin
               code_in  = rx_byte;
               sum_in   = sum_add;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = rx_byte;
               sum_in   = sum_add;
               count_in = '0;
               if (rx_byte > 8'(MAX_PAYLOAD)) begin
                  phase_in = PH_SYNC1;
                  q_push   = 1'b1;
                  q_desc   = '{status: ST_LEN_ERR, code: code_ff, length: rx_byte};
               end else if (rx_byte == 8'd0) begin
                  phase_in = PH_SUM;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               st_wr.en = (count_ff < CNT_W'(MAX_PAYLOAD));
               sum_in   = sum_add;
               count_in = count_inc;
               if ({{(8-CNT_W){1'b0}}, count_inc} >= len_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               phase_in = PH_SYNC1;
               count_in = '0;
               q_push   = 1'b1;
               if (rx_byte != sum_ff) begin
                  q_desc.status = ST_SUM_ERR;
               end else if (len_ff == 8'd0) begin
                  q_desc.status = ST_EMPTY;
               end else begin
                  q_desc.status = ST_DATA;
               end
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         count_ff <= '0;
         len_ff   <= '0;
         code_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         code_ff  <= code_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= FIRST_SYNC_RESET;
         second_ff <= SECOND_SYNC_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_SYNC:  first_ff  <= csr_data;
            CSR_SECOND_SYNC: second_ff <= csr_data;
            default:         first_ff  <= first_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/cfr_queue.sv
// ---------------------------------------------------------------------------
// cfr_queue
// Small FIFO of finished frame descriptors between front and back.
// ---------------------------------------------------------------------------
module cfr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  cfr_pkg::frame_desc_type wr_desc,
   input  logic                    rd_en,
   output cfr_pkg::frame_desc_type rd_desc,
   output cfr_pkg::queue_stat_type stat
);
   import cfr_pkg::*;

   frame_desc_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_wr, do_rd;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && !stat.empty;
   assign rd_desc    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({do_wr, do_rd})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/cfr_back.sv
// ---------------------------------------------------------------------------
// cfr_back
// Result emitter: payload memory; frame results, one per cycle while popped.
// ---------------------------------------------------------------------------
module cfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cfr_pkg::store_wr_type   st_wr,
   input  cfr_pkg::queue_stat_type q_stat,
   input  cfr_pkg::frame_desc_type q_desc,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic [1:0]              status,
   output logic [7:0]              function_code,
   output logic [7:0]              payload_byte,
   output logic [4:0]              byte_index,
   output logic [7:0]              frame_length,
   output logic                    last
);
   import cfr_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } back_state_type;

   logic [7:0]       mem [MAX_PAYLOAD];

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             valid_ff;
   logic [1:0]       status_ff;
   logic [7:0]       code_ff;
   logic [7:0]       data_ff;
   logic [IDX_W-1:0] index_ff;
   logic [7:0]       length_ff;
   logic             last_ff;

   logic             can_load;
   logic             issue;
   logic             issue_last;
   logic             is_data;
   logic [CNT_W-1:0] k_cur;
   logic [CNT_W-1:0] k_next;

   assign can_load = !valid_ff || pop;
   assign is_data  = (q_desc.status == ST_DATA);
   assign k_next   = k_cur + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      issue      = 1'b0;
      issue_last = 1'b1;
      k_cur      = '0;
      q_pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            k_cur = '0;
            if (!q_stat.empty && can_load) begin
               issue      = 1'b1;
               issue_last = !is_data || (q_desc.length == 8'd1);
               if (issue_last) begin
                  q_pop = 1'b1;
               end else begin
                  state_in = BK_RUN;
                  k_in     = k_next;
               end
            end
         end
         BK_RUN: begin
            k_cur = k_ff;
            if (can_load) begin
               issue      = 1'b1;
               issue_last = ({{(8-CNT_W){1'b0}}, k_next} == q_desc.length);
               if (issue_last) begin
                  q_pop    = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  k_in = k_next;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_wr.en) begin
         mem[st_wr.addr] <= st_wr.data;
      end
   end

   // read data register doubles as the output payload register
   always_ff @(posedge clock) begin
      if (issue) begin
         data_ff   <= is_data ? mem[k_cur[ADDR_W-1:0]] : 8'd0;
         status_ff <= q_desc.status;
         code_ff   <= q_desc.code;
         length_ff <= q_desc.length;
         index_ff  <= is_data ? IDX_W'(k_cur) : '0;
         last_ff   <= issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (issue) begin
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign empty         = !valid_ff;
   assign status        = status_ff;
   assign function_code = code_ff;
   assign payload_byte  = data_ff;
   assign byte_index    = index_ff;
   assign frame_length  = length_ff;
   assign last          = last_ff;

endmodule

// File: rtl/core/checksum_frame_receiver.sv
// ---------------------------------------------------------------------------
// checksum_frame_receiver
// Deframes sync/code/length/payload/checksum frames from a serial byte stream.
// ---------------------------------------------------------------------------
// The parser takes one received byte per clock as long as full is low. A frame
// that ends (checksum byte, or a length field above 32) is queued for the
// emitter; when the emitter is free it loads its first result from the queue
// entry into its result registers. There is one result for an empty
// frame, a bad checksum or a bad length, and one result per payload byte at one
// per clock while pop stays high for a good frame, read out of the 32-byte
// payload memory. Because that memory has a single copy, payload bytes of the
// next frame hold full high until every queued frame has issued its results;
// header, sync and checksum bytes are still taken meanwhile unless both queue
// entries are taken, which holds full high for every byte. Up to two finished
// frames wait between parser and emitter. csr_ready is always high; write sync
// values only while the block is idle.
module checksum_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_function_code,
   output logic [7:0] rsp_payload_byte,
   output logic [4:0] rsp_byte_index,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import cfr_pkg::*;

   queue_stat_type q_stat;
   frame_desc_type wr_desc;
   frame_desc_type rd_desc;
   store_wr_type   st_wr;
   logic           q_push;
   logic           q_pop;

   assign csr_ready = 1'b1;

   cfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rx_byte   (req_rx_byte),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_desc    (wr_desc),
      .st_wr     (st_wr)
   );

   cfr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_desc (wr_desc),
      .rd_en   (q_pop),
      .rd_desc (rd_desc),
      .stat    (q_stat)
   );

   cfr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .st_wr         (st_wr),
      .q_stat        (q_stat),
      .q_desc        (rd_desc),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .status        (rsp_status),
      .function_code (rsp_function_code),
      .payload_byte  (rsp_payload_byte),
      .byte_index    (rsp_byte_index),
      .frame_length  (rsp_frame_length),
      .last          (rsp_last)
   );

endmodule

// File: rtl/core/cfr_checker.sv
// ---------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the frame receiver result channel.
// ---------------------------------------------------------------------------
`include "checksum_frame_receiver_defines.svh"

module cfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_payload_byte,
   input logic [4:0] rsp_byte_index,
   input logic [7:0] rsp_frame_length,
   input logic       rsp_last
);
   import cfr_pkg::*;

   logic [7:0] index_next;

   assign index_next = {3'b000, rsp_byte_index} + 8'd1;

   `CFR_ASSERT_RST(a_reset_empty, reset, empty, "result visible right after reset")
   `CFR_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(rsp_status) && $stable(rsp_payload_byte), "waiting result changed before transfer")
   `CFR_ASSERT_NOW(a_status_shape, !empty && rsp_status != ST_DATA, rsp_last && rsp_payload_byte == 8'd0 && rsp_byte_index == 5'd0, "non-payload result malformed")
   `CFR_ASSERT_NOW(a_index_range, !empty && rsp_status == ST_DATA, index_next <= rsp_frame_length && (rsp_last == (index_next == rsp_frame_length)), "payload index or last mark wrong")

endmodule

bind checksum_frame_receiver cfr_checker u_cfr_checker (.*);

// File: sim/checksum_frame_receiver_checker.sv
// ---------------------------------------------------------------------------
// checksum_frame_receiver_checker
// Watches the byte, result and register channels of the frame receiver,
// predicts every result from the accepted bytes and compares in order.
// ---------------------------------------------------------------------------
module checksum_frame_receiver_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] rx_byte,
   input  logic       empty,
   input  logic       pop,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_function_code,
   input  logic [7:0] rsp_payload_byte,
   input  logic [4:0] rsp_byte_index,
   input  logic [7:0] rsp_frame_length,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data,
   output int         mismatch_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import cfr_pkg::*;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_CODE,
      TAKE_LENGTH,
      TAKE_PAYLOAD,
      TAKE_SUM
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] code;
      logic [7:0] data;
      logic [4:0] index;
      logic [7:0] length;
      logic       last;
   } frame_result_type;

   // shadow of the parser
   logic [7:0]      first_sync_q;
   logic [7:0]      second_sync_q;
   parse_phase_type phase_q;
   int              count_q;
   logic [7:0]      length_q;
   logic [7:0]      code_q;
   logic [7:0]      sum_q;
   logic [7:0]      payload_q [MAX_PAYLOAD];

   frame_result_type expected_results [$];
   frame_result_type got;
   frame_result_type want;
   int               fails   = 0;
   int               waiting = 0;

   assign mismatch_count = fails;
   assign pending_count  = waiting;

   task automatic add_result(input logic [1:0] status, input logic [7:0] data,
                             input logic [4:0] index, input logic last);
      expected_results.push_back('{status, code_q, data, index, length_q, last});
   endtask

   task automatic parse_rx_byte(input logic [7:0] b);
      case (phase_q)
         HUNT_FIRST: begin
            if (b == first_sync_q) begin
               sum_q   = b;
               phase_q = HUNT_SECOND;
            end
         end
         HUNT_SECOND: begin
            // a mismatch here is dropped, not retried as a first sync
            if (b == second_sync_q) begin
               sum_q   = sum_q + b;
               phase_q = TAKE_CODE;
            end else begin
               phase_q = HUNT_FIRST;
            end
         end
         TAKE_CODE: begin
            code_q  = b;
            sum_q   = sum_q + b;
            phase_q = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            length_q = b;
            sum_q    = sum_q + b;
            count_q  = 0;
            if (b > MAX_PAYLOAD) begin
               phase_q = HUNT_FIRST;
               add_result(ST_LEN_ERR, 8'h00, 5'd0, 1'b1);
            end else begin
               phase_q = (b == 8'd0) ? TAKE_SUM : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            if (count_q < MAX_PAYLOAD)
               payload_q[count_q] = b;
            sum_q   = sum_q + b;
            count_q = count_q + 1;
            if (count_q >= length_q)
               phase_q = TAKE_SUM;
         end
         default: begin
            phase_q = HUNT_FIRST;
            count_q = 0;
            if (b != sum_q) begin
               add_result(ST_SUM_ERR, 8'h00, 5'd0, 1'b1);
            end else if (length_q == 8'd0) begin
               add_result(ST_EMPTY, 8'h00, 5'd0, 1'b1);
            end else begin
               for (int k = 0; k < length_q && k < MAX_PAYLOAD; k++)
                  add_result(ST_DATA, payload_q[k], 5'(k), (k + 1 == length_q));
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_sync_q  = FIRST_SYNC_RESET;
         second_sync_q = SECOND_SYNC_RESET;
         phase_q       = HUNT_FIRST;
         count_q       = 0;
         length_q      = 8'h00;
         code_q        = 8'h00;
         sum_q         = 8'h00;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIRST_SYNC)
               first_sync_q = csr_data;
            else
               second_sync_q = csr_data;
         end
         if (push && !full)
            parse_rx_byte(rx_byte);
         if (pop && !empty) begin
            got = '{rsp_status, rsp_function_code, rsp_payload_byte, rsp_byte_index,
                    rsp_frame_length, rsp_last};
            if (expected_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result: status %0d code %02h data %02h",
                           $time, got.status, got.code, got.data,
                           " index %0d length %0d last %0b",
                           got.index, got.length, got.last);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: result mismatch: expected status %0d code %02h",
                              $time, want.status, want.code,
                              " data %02h index %0d length %0d last %0b;",
                              want.data, want.index, want.length, want.last,
                              " got status %0d code %02h data %02h index %0d",
                              got.status, got.code, got.data, got.index,
                              " length %0d last %0b", got.length, got.last);
               end
            end
         end
      end
      waiting = expected_results.size();
   end

endmodule

// File: sim/checksum_frame_receiver_tb.sv
// ---------------------------------------------------------------------------
// checksum_frame_receiver_tb
// Feeds framed and broken byte streams under several sync settings and
// idle patterns; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module checksum_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfr_pkg::*;

   logic       clock;
   logic       reset       = 1'b1;
   logic       push        = 1'b0;
   logic       full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       empty;
   logic       pop         = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_function_code;
   logic [7:0] rsp_payload_byte;
   logic [4:0] rsp_byte_index;
   logic [7:0] rsp_frame_length;
   logic       rsp_last;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic       csr_index   = CSR_FIRST_SYNC;
   logic [7:0] csr_data    = 8'h00;

   int mismatch_count;
   int pending_count;

   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         bytes_sent    = 0;
   logic [7:0] sync_first    = FIRST_SYNC_RESET;
   logic [7:0] sync_second   = SECOND_SYNC_RESET;

   checksum_frame_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_function_code (rsp_function_code),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   checksum_frame_receiver_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .rx_byte           (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_function_code (rsp_function_code),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // push stays high across back-to-back transfers
   task automatic put_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full)
         @(posedge clock);
      bytes_sent++;
   endtask

   // fill < 0 gives random payload bytes
   task automatic send_frame(input logic [7:0] code, input logic [7:0] len,
                             input int fill, input bit bad_sum);
      logic [7:0] frame_sum;
      logic [7:0] b;
      frame_sum = sync_first + sync_second + code + len;
      put_byte(sync_first);
      put_byte(sync_second);
      put_byte(code);
      put_byte(len);
      if (len <= MAX_PAYLOAD) begin
         for (int i = 0; i < len; i++) begin
            b         = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
            frame_sum = frame_sum + b;
            put_byte(b);
         end
         if (bad_sum)
            frame_sum = frame_sum ^ (8'd1 << $urandom_range(7));
         put_byte(frame_sum);
      end
   endtask

   task automatic write_syncs(input logic [7:0] s1, input logic [7:0] s2);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_SYNC;
      csr_data  <= s1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_index <= CSR_SECOND_SYNC;
      csr_data  <= s2;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid   <= 1'b0;
      sync_first  = s1;
      sync_second = s2;
   endtask

   // mostly well-formed frames, some bad sums, bad lengths and stray bytes
   task automatic random_traffic(input int n);
      int         stop_at;
      int         pick;
      int         r;
      logic [7:0] len;
      logic [7:0] b;
      stop_at = bytes_sent + n;
      send_frame(8'($urandom_range(255)), MAX_PAYLOAD, -1, 1'b0);
      while (bytes_sent < stop_at) begin
         r    = $urandom_range(99);
         len  = (r < 8)  ? 8'(MAX_PAYLOAD) :
                (r < 20) ? 8'($urandom_range(MAX_PAYLOAD - 1, 9)) :
                           8'($urandom_range(8));
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame(8'($urandom_range(255)), len, -1, 1'b0);
         end else if (pick < 77) begin
            send_frame(8'($urandom_range(255)), len, -1, 1'b1);
         end else if (pick < 85) begin
            send_frame(8'($urandom_range(255)),
                       8'($urandom_range(255, MAX_PAYLOAD + 1)), -1, 1'b0);
         end else if (pick < 92) begin
            b = 8'($urandom_range(255));
            if (b == sync_second)
               b = ~b;
            put_byte(sync_first);
            put_byte(b);
         end else begin
            repeat ($urandom_range(3, 1))
               put_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // drain all expected results, then let the pipeline go quiet
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 53;
      send_frame(8'h00, 8'd0, 0, 1'b0);
      send_frame(8'hFF, 8'd1, 8'hFF, 1'b0);
      send_frame(8'h05, 8'd0, 0, 1'b1);
      send_frame(8'h04, 8'(MAX_PAYLOAD + 1), 0, 1'b0);
      send_frame(8'h3C, 8'hFF, 0, 1'b0);
      put_byte(8'h55);
      // second sync miss: the repeated first sync must not restart the frame
      put_byte(sync_first);
      put_byte(sync_first);
      put_byte(sync_second);
      random_traffic(65);
      settle();

      write_syncs(8'h00, 8'hFF);
      random_traffic(65);
      settle();

      send_idle_pct = 53;
      recv_idle_pct = 20;
      write_syncs(8'hFF, 8'h00);
      random_traffic(65);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
      random_traffic(65);
      settle();

      if (mismatch_count == 0)
         $display("[checksum_frame_receiver] OK");
      else
         $display("[checksum_frame_receiver] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[checksum_frame_receiver] ERROR");
      $finish;
   end

endmodule

// File: checksum_frame_receiver.f
+incdir+rtl/core
rtl/core/cfr_pkg.sv
rtl/core/cfr_front.sv
rtl/core/cfr_queue.sv
rtl/core/cfr_back.sv
rtl/core/checksum_frame_receiver.sv
rtl/core/cfr_checker.sv
sim/checksum_frame_receiver_checker.sv
sim/checksum_frame_receiver_tb.sv
